@@ rtl/core/sitda_pkg.sv @@
// Shared constants, types and conversion functions for the decimal ASCII converter.
package sitda_pkg;

    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 6;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
    localparam int DD_STAGES  = 4;
    localparam int DD_STEPS   = VALUE_W / DD_STAGES;
    localparam int PIPE_DEPTH = DD_STAGES + 1;
    localparam int IDX_W      = 4;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

    typedef struct packed {
        logic               neg;
        logic [BCD_W-1:0]   bcd;
        logic [VALUE_W-1:0] bin;
    } dd_word_t;

    // Eight shift-and-add-3 steps of the double dabble conversion.
    function automatic dd_word_t dd_steps(dd_word_t w);
        dd_word_t                   r;
        logic [BCD_W+VALUE_W-1:0]   sr;
        r = w;
        for (int s = 0; s < DD_STEPS; s++) begin
            for (int d = 0; d < NUM_DIGITS; d++) begin
                if (r.bcd[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
                    r.bcd[d*DIGIT_W +: DIGIT_W] = r.bcd[d*DIGIT_W +: DIGIT_W] + 4'd3;
                end
            end
            sr    = {r.bcd, r.bin} << 1;
            r.bcd = sr[BCD_W+VALUE_W-1 -: BCD_W];
            r.bin = sr[VALUE_W-1:0];
        end
        return r;
    endfunction

    // Position of the most significant nonzero digit; zero maps to the units digit.
    function automatic logic [IDX_W-1:0] msd_index(logic [BCD_W-1:0] bcd);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int d = 1; d < NUM_DIGITS; d++) begin
            if (bcd[d*DIGIT_W +: DIGIT_W] != '0) begin
                idx = IDX_W'(d);
            end
        end
        return idx;
    endfunction

endpackage

@@ rtl/core/signed_int_to_decimal_ascii_core.sv @@
// Signed 32-bit integer to decimal ASCII text converter, pipelined core.
//
//   Channel  | Handshake             | Payload               | Direction
//   ---------+-----------------------+-----------------------+----------
//   command  | start / busy          | value[31:0] signed    | in
//   result   | result_valid (strobe) | character[5:0],       | out
//            |                       | last_char             |
//
// A transaction is accepted at a rising edge with start high and busy low.
// The value passes a magnitude stage and four double dabble stages of eight
// steps each, then the serializer registers and the output registers.
// The serializer emits one character per cycle while active, so a number
// gives one to eleven characters, and their count sets the sustained rate.
// The pipeline stages hold up to five more numbers; busy rises when they fill.
// Reset empties the pipeline and the serializer; the receiver cannot stall.
module signed_int_to_decimal_ascii_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [sitda_pkg::VALUE_W-1:0] value,
    output logic                                busy,
    output logic                                result_valid,
    output logic [sitda_pkg::CHAR_W-1:0]        character,
    output logic                                last_char
);
    import sitda_pkg::*;

    // Pipeline stage 0 holds sign and magnitude; stages 1 to 4 run the
    // double dabble steps. Each stage carries its own valid bit.
    dd_word_t                  pipe_reg     [PIPE_DEPTH];
    dd_word_t                  pipe_next    [PIPE_DEPTH];
    logic [PIPE_DEPTH-1:0]     pipe_vld_reg;
    logic [PIPE_DEPTH-1:0]     pipe_vld_next;
    logic [PIPE_DEPTH:0]       rdy;

    // Serializer state.
    logic                      act_reg, act_next;
    logic                      sgn_reg, sgn_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [BCD_W-1:0]          bcd_reg, bcd_next;
    logic                      rv_reg, rv_next;
    logic [CHAR_W-1:0]         char_reg, char_next;
    logic                      last_reg, last_next;

    logic                      ser_rdy;
    logic                      ser_load;
    logic                      take;
    logic [VALUE_W-1:0]        raw;
    logic [DIGIT_W-1:0]        cur_digit;

    assign raw = value;

    // The serializer can take a new number when idle or on its final character.
    assign ser_rdy = !act_reg || (!sgn_reg && (idx_reg == '0));

    // A stage may load when it is empty or its contents move on this cycle.
    always_comb
    begin
        rdy[PIPE_DEPTH] = ser_rdy;
        for (int i = PIPE_DEPTH - 1; i >= 0; i--) begin
            rdy[i] = !pipe_vld_reg[i] || rdy[i+1];
        end
    end

    assign busy     = !rdy[0];
    assign take     = start && !busy;
    assign ser_load = pipe_vld_reg[PIPE_DEPTH-1] && ser_rdy;

    always_comb
    begin
        pipe_vld_next = pipe_vld_reg;
        for (int i = 0; i < PIPE_DEPTH; i++) begin
            pipe_next[i] = pipe_reg[i];
        end
        if (rdy[0]) begin
            pipe_vld_next[0] = take;
            pipe_next[0].neg = raw[VALUE_W-1];
            pipe_next[0].bcd = '0;
            pipe_next[0].bin = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;
        end
        for (int i = 1; i < PIPE_DEPTH; i++) begin
            if (rdy[i]) begin
                pipe_vld_next[i] = pipe_vld_reg[i-1];
                pipe_next[i]     = dd_steps(pipe_reg[i-1]);
            end
        end
    end

    assign cur_digit = bcd_reg[idx_reg*DIGIT_W +: DIGIT_W];

    // The minus sign goes out first, then digits from the most significant down.
    always_comb
    begin
        act_next  = act_reg;
        sgn_next  = sgn_reg;
        idx_next  = idx_reg;
        bcd_next  = bcd_reg;
        rv_next   = 1'b0;
        char_next = char_reg;
        last_next = 1'b0;
        if (act_reg) begin
            rv_next = 1'b1;
            if (sgn_reg) begin
                char_next = ASCII_MINUS;
                sgn_next  = 1'b0;
            end
            else begin
                char_next = ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, cur_digit};
                last_next = (idx_reg == '0);
                if (idx_reg == '0) begin
                    act_next = 1'b0;
                end
                else begin
                    idx_next = idx_reg - 1'b1;
                end
            end
        end
        if (ser_load) begin
            act_next = 1'b1;
            sgn_next = pipe_reg[PIPE_DEPTH-1].neg;
            bcd_next = pipe_reg[PIPE_DEPTH-1].bcd;
            idx_next = msd_index(pipe_reg[PIPE_DEPTH-1].bcd);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pipe_vld_reg <= '0;
            act_reg      <= 1'b0;
            sgn_reg      <= 1'b0;
            idx_reg      <= '0;
            rv_reg       <= 1'b0;
            last_reg     <= 1'b0;
        end
        else begin
            pipe_vld_reg <= pipe_vld_next;
            act_reg      <= act_next;
            sgn_reg      <= sgn_next;
            idx_reg      <= idx_next;
            rv_reg       <= rv_next;
            last_reg     <= last_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < PIPE_DEPTH; i++) begin
            pipe_reg[i] <= pipe_next[i];
        end
        bcd_reg  <= bcd_next;
        char_reg <= char_next;
    end

    assign result_valid = rv_reg;
    assign character    = char_reg;
    assign last_char    = last_reg;

    // A minus sign is never the final character of a number.
    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (character == ASCII_MINUS)) |-> !last_char)
        else $error("minus sign marked as last character");

    // A minus sign is always followed at once by another character.
    a_minus_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (character == ASCII_MINUS)) |=> result_valid)
        else $error("gap after minus sign");

    // An active serializer produces a character in the next cycle.
    a_active_emits: assert property (@(posedge clk) disable iff (!rst_n)
        act_reg |=> result_valid)
        else $error("serializer active without output");

    // An accepted transaction always occupies the first stage.
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> pipe_vld_reg[0])
        else $error("accepted transaction lost at entry");

endmodule
